[hw/rtl/k_smallest_max_heap_defines.svh]
// Assertion macros used by the k-smallest heap datapath.
`ifndef K_SMALLEST_MAX_HEAP_DEFINES_SVH
`define K_SMALLEST_MAX_HEAP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define KSMH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define KSMH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ksmh_pkg.sv]
// Package with the types, codes and widths of the k-smallest heap.
package ksmh_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int KEY_W        = 32;
    localparam int ID_W         = 32;
    localparam int OP_W         = 2;
    localparam int ST_W         = 3;
    localparam int FILL_W       = 6;
    localparam int K_W          = 6;
    localparam logic [K_W-1:0] K_RESET = 6'd32;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DRAIN  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_APPEND  = 3'd0,
        ST_REPLACE = 3'd1,
        ST_DISCARD = 3'd2,
        ST_DRAINED = 3'd3,
        ST_CLEARED = 3'd4,
        ST_EMPTY   = 3'd5
    } t_status;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_APPEND,
        CMD_RD_ROOT,
        CMD_DISCARD,
        CMD_CLEAR,
        CMD_EMPTY,
        CMD_SD_INIT,
        CMD_WR_CUR,
        CMD_RD_PAR,
        CMD_UP_MOVE,
        CMD_RD_L,
        CMD_SD_L,
        CMD_SD_R,
        CMD_SD_MOVE,
        CMD_DR_INIT,
        CMD_DR_TMP,
        CMD_DR_SWAP,
        CMD_EM_INIT,
        CMD_EM_RD,
        CMD_EM_OUT,
        CMD_EMIT_ROOT
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic not_full;
        logic count_zero;
        logic node_zero;
        logic gt_parent;
        logic lt_root;
        logic has_l;
        logic has_r;
        logic big_is_node;
        logic i_zero;
        logic em_last;
        logic drain;
        logic out_free;
    } t_dp_status;

endpackage

[hw/rtl/ksmh_in_if.sv]
// Input channel interface: one beat carries an operation and a key pair.
interface ksmh_in_if;
    logic                       valid;
    logic                       ready;
    logic [ksmh_pkg::OP_W-1:0]  operation;
    logic [ksmh_pkg::KEY_W-1:0] key_value;
    logic [ksmh_pkg::ID_W-1:0]  item_index;

    modport source (output valid, operation, key_value, item_index, input ready);
    modport sink (input valid, operation, key_value, item_index, output ready);
endinterface

[hw/rtl/ksmh_out_if.sv]
// Output channel interface: one beat carries one result.
interface ksmh_out_if;
    logic                        valid;
    logic                        ready;
    logic [ksmh_pkg::ST_W-1:0]   status;
    logic [ksmh_pkg::KEY_W-1:0]  out_key;
    logic [ksmh_pkg::ID_W-1:0]   out_index;
    logic [ksmh_pkg::FILL_W-1:0] fill_count;
    logic                        last;

    modport source (output valid, status, out_key, out_index, fill_count, last, input ready);
    modport sink (input valid, status, out_key, out_index, fill_count, last, output ready);
endinterface

[hw/rtl/k_smallest_max_heap.sv]
// Top level of the bounded max-heap that keeps the k smallest key pairs.
// An insert appends and sifts up, replaces the root and sifts down, or is discarded; clear,
// an empty drain and reserved code 3 give one result beat. A drain of n entries runs n - 1
// heap-sort passes, then sends one beat per entry. The next beat is taken only after the
// result is loaded. Reset (synchronous, active low) empties the heap and sets k to 32; RAM
// contents stay as is.
module k_smallest_max_heap #(
    parameter int CAPACITY = ksmh_pkg::CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ksmh_in_if.sink                  i_in,
    ksmh_out_if.source               o_out,
    input  logic                     i_cfg_we,
    input  logic [ksmh_pkg::K_W-1:0] i_cfg_wdata
);
    // The controller and datapath talk only through a command and a status word.
    ksmh_pkg::t_cmd       w_cmd;
    ksmh_pkg::t_dp_status w_status;
    logic                 w_in_ready;

    // An input beat is taken only while the controller is idle; the output
    // register lets a finished result wait while the next beat is accepted.
    assign i_in.ready = w_in_ready;

    ksmh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the heap RAM, the sift registers, the count, the k
    // register and the output register.
    ksmh_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_operation  (i_in.operation),
        .i_key_value  (i_in.key_value),
        .i_item_index (i_in.item_index),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_out        (o_out)
    );
endmodule

[hw/rtl/ksmh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ksmh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/ksmh_datapath.sv]
// Datapath: heap RAM, sift registers, fill count, config and output register.
`include "k_smallest_max_heap_defines.svh"
module ksmh_datapath #(
    parameter int CAPACITY = ksmh_pkg::CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ksmh_pkg::OP_W-1:0]   i_operation,
    input  logic [ksmh_pkg::KEY_W-1:0]  i_key_value,
    input  logic [ksmh_pkg::ID_W-1:0]   i_item_index,
    input  logic                        i_cfg_we,
    input  logic [ksmh_pkg::K_W-1:0]    i_cfg_wdata,
    input  ksmh_pkg::t_cmd              i_cmd,
    output ksmh_pkg::t_dp_status        o_status,
    ksmh_out_if.source                  o_out
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 2;
    localparam int KW = ksmh_pkg::KEY_W;
    localparam int IW = ksmh_pkg::ID_W;

    logic [ksmh_pkg::K_W-1:0] r_k, n_k;
    logic [CW-1:0]            r_count, n_count;
    ksmh_pkg::t_op            r_op, n_op;
    ksmh_pkg::t_status        r_status, n_status;
    logic [KW-1:0]            r_cur_key, n_cur_key, r_big_key, n_big_key, r_tmp_key, n_tmp_key;
    logic [IW-1:0]            r_cur_id, n_cur_id, r_big_id, n_big_id, r_tmp_id, n_tmp_id;
    logic [AW-1:0]            r_big_idx, n_big_idx, r_node, n_node, r_i, n_i;
    logic [CW-1:0]            r_bound, n_bound, r_n, n_n;

    logic                          r_out_valid, n_out_valid;
    ksmh_pkg::t_status             r_out_status, n_out_status;
    logic [KW-1:0]                 r_out_key, n_out_key;
    logic [IW-1:0]                 r_out_id, n_out_id;
    logic [ksmh_pkg::FILL_W-1:0]   r_out_fill, n_out_fill;
    logic                          r_out_last, n_out_last;
    logic                          w_out_load;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [KW+IW-1:0]     ram_wdata, ram_rdata;
    logic [KW-1:0]        rd_key;
    logic [IW-1:0]        rd_id;

    logic [CW-1:0]        w_eff_k;
    logic [LW-1:0]        w_l, w_r;
    logic [AW-1:0]        w_parent;
    logic                 w_out_free;

    ksmh_ram #(.WIDTH(KW + IW), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[KW+IW-1:IW];
    assign rd_id  = ram_rdata[IW-1:0];

    // A k of zero acts as one, a k above the capacity as the capacity.
    always_comb begin
        if (r_k == '0) begin
            w_eff_k = CW'(1);
        end else if (int'(r_k) > CAPACITY) begin
            w_eff_k = CW'(CAPACITY);
        end else begin
            w_eff_k = CW'(r_k);
        end
    end

    assign w_l        = LW'({r_node, 1'b1});
    assign w_r        = w_l + LW'(1);
    assign w_parent   = (r_node - AW'(1)) >> 1;
    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        o_status.op          = r_op;
        o_status.not_full    = r_count < w_eff_k;
        o_status.count_zero  = r_count == '0;
        o_status.node_zero   = r_node == '0;
        o_status.gt_parent   = r_cur_key > rd_key;
        o_status.lt_root     = r_cur_key < rd_key;
        o_status.has_l       = w_l < LW'(r_bound);
        o_status.has_r       = w_r < LW'(r_bound);
        o_status.big_is_node = r_big_idx == r_node;
        o_status.i_zero      = r_i == '0;
        o_status.em_last     = (CW'(r_i) + CW'(1)) == r_n;
        o_status.drain       = r_op == ksmh_pkg::OP_DRAIN;
        o_status.out_free    = w_out_free;
    end

    always_comb begin
        n_k = r_k;  n_count = r_count;  n_op = r_op;  n_status = r_status;
        n_cur_key = r_cur_key;  n_cur_id = r_cur_id;
        n_big_key = r_big_key;  n_big_id = r_big_id;  n_big_idx = r_big_idx;
        n_tmp_key = r_tmp_key;  n_tmp_id = r_tmp_id;
        n_node = r_node;  n_bound = r_bound;  n_i = r_i;  n_n = r_n;
        n_out_status = r_out_status;  n_out_key = r_out_key;  n_out_id = r_out_id;
        n_out_fill = r_out_fill;  n_out_last = r_out_last;
        w_out_load = 1'b0;
        ram_we = 1'b0;  ram_waddr = r_node;  ram_wdata = {r_cur_key, r_cur_id};
        ram_re = 1'b0;  ram_raddr = '0;

        if (i_cfg_we) begin
            n_k = i_cfg_wdata;
        end

        unique case (i_cmd)
            ksmh_pkg::CMD_LOAD: begin
                n_op      = ksmh_pkg::t_op'(i_operation);
                n_cur_key = i_key_value;
                n_cur_id  = i_item_index;
            end
            ksmh_pkg::CMD_APPEND: begin
                n_node   = AW'(r_count);
                n_count  = r_count + CW'(1);
                n_status = ksmh_pkg::ST_APPEND;
            end
            ksmh_pkg::CMD_RD_ROOT: begin
                ram_re = 1'b1;
            end
            ksmh_pkg::CMD_DISCARD: begin
                n_status = ksmh_pkg::ST_DISCARD;
            end
            ksmh_pkg::CMD_CLEAR: begin
                n_count  = '0;
                n_status = ksmh_pkg::ST_CLEARED;
            end
            ksmh_pkg::CMD_EMPTY: begin
                n_status = ksmh_pkg::ST_EMPTY;
            end
            ksmh_pkg::CMD_SD_INIT: begin
                n_node   = '0;
                n_bound  = r_count;
                n_status = ksmh_pkg::ST_REPLACE;
            end
            ksmh_pkg::CMD_WR_CUR: begin
                ram_we = 1'b1;
            end
            ksmh_pkg::CMD_RD_PAR: begin
                ram_re    = 1'b1;
                ram_raddr = w_parent;
            end
            ksmh_pkg::CMD_UP_MOVE: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_node    = w_parent;
            end
            ksmh_pkg::CMD_RD_L: begin
                n_big_key = r_cur_key;
                n_big_id  = r_cur_id;
                n_big_idx = r_node;
                ram_re    = 1'b1;
                ram_raddr = AW'(w_l);
            end
            ksmh_pkg::CMD_SD_L: begin
                if (rd_key > r_big_key) begin
                    n_big_key = rd_key;
                    n_big_id  = rd_id;
                    n_big_idx = AW'(w_l);
                end
                ram_re    = 1'b1;
                ram_raddr = AW'(w_r);
            end
            ksmh_pkg::CMD_SD_R: begin
                if (rd_key > r_big_key) begin
                    n_big_key = rd_key;
                    n_big_id  = rd_id;
                    n_big_idx = AW'(w_r);
                end
            end
            ksmh_pkg::CMD_SD_MOVE: begin
                ram_we    = 1'b1;
                ram_wdata = {r_big_key, r_big_id};
                n_node    = r_big_idx;
            end
            ksmh_pkg::CMD_DR_INIT: begin
                n_n = r_count;
                n_i = AW'(r_count - CW'(1));
            end
            ksmh_pkg::CMD_DR_TMP: begin
                n_tmp_key = rd_key;
                n_tmp_id  = rd_id;
                ram_re    = 1'b1;
                ram_raddr = r_i;
            end
            ksmh_pkg::CMD_DR_SWAP: begin
                n_cur_key = rd_key;
                n_cur_id  = rd_id;
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = {r_tmp_key, r_tmp_id};
                n_node    = '0;
                n_bound   = CW'(r_i);
                n_i       = r_i - AW'(1);
            end
            ksmh_pkg::CMD_EM_INIT: begin
                n_i = '0;
            end
            ksmh_pkg::CMD_EM_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_i;
            end
            ksmh_pkg::CMD_EM_OUT: begin
                w_out_load   = 1'b1;
                n_out_status = ksmh_pkg::ST_DRAINED;
                n_out_key    = rd_key;
                n_out_id     = rd_id;
                n_out_fill   = ksmh_pkg::FILL_W'(r_n - CW'(r_i) - CW'(1));
                n_out_last   = o_status.em_last;
                n_i          = r_i + AW'(1);
                if (o_status.em_last) begin
                    n_count = '0;
                end
            end
            ksmh_pkg::CMD_EMIT_ROOT: begin
                w_out_load   = 1'b1;
                n_out_status = r_status;
                n_out_key    = (r_count != '0) ? rd_key : '0;
                n_out_id     = (r_count != '0) ? rd_id : '0;
                n_out_fill   = ksmh_pkg::FILL_W'(r_count);
                n_out_last   = 1'b1;
            end
            default: begin
            end
        endcase

        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= ksmh_pkg::K_RESET;
            r_count     <= '0;
            r_op        <= ksmh_pkg::OP_INSERT;
            r_status    <= ksmh_pkg::ST_APPEND;
            r_out_valid <= 1'b0;
        end else begin
            r_k         <= n_k;
            r_count     <= n_count;
            r_op        <= n_op;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_key    <= n_cur_key;
        r_cur_id     <= n_cur_id;
        r_big_key    <= n_big_key;
        r_big_id     <= n_big_id;
        r_big_idx    <= n_big_idx;
        r_tmp_key    <= n_tmp_key;
        r_tmp_id     <= n_tmp_id;
        r_node       <= n_node;
        r_bound      <= n_bound;
        r_i          <= n_i;
        r_n          <= n_n;
        r_out_status <= n_out_status;
        r_out_key    <= n_out_key;
        r_out_id     <= n_out_id;
        r_out_fill   <= n_out_fill;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.out_key    = r_out_key;
    assign o_out.out_index  = r_out_id;
    assign o_out.fill_count = r_out_fill;
    assign o_out.last       = r_out_last;

    `KSMH_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(CAPACITY), "fill count above capacity")
    `KSMH_ASSERT_NOW(a_append_room, i_cmd == ksmh_pkg::CMD_APPEND, r_count < w_eff_k, "append into a full heap")
    `KSMH_ASSERT_NEXT(a_clear_empties, i_cmd == ksmh_pkg::CMD_CLEAR, r_count == '0, "clear left entries")
    `KSMH_ASSERT_NOW(a_load_free, w_out_load, !r_out_valid || o_out.ready, "result overwrote a waiting beat")
endmodule

[hw/rtl/ksmh_ctrl.sv]
// Controller state machine that sequences inserts, sift passes, drains and clears.
module ksmh_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ksmh_pkg::t_dp_status i_status,
    output ksmh_pkg::t_cmd       o_cmd
);
    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_DEC      = 16'h0002,
        S_UP       = 16'h0004,
        S_UP_CMP   = 16'h0008,
        S_CHK_ROOT = 16'h0010,
        S_SD       = 16'h0020,
        S_SD_L     = 16'h0040,
        S_SD_R     = 16'h0080,
        S_SD_DEC   = 16'h0100,
        S_ROOT_RD  = 16'h0200,
        S_ROOT_OUT = 16'h0400,
        S_DR_LOOP  = 16'h0800,
        S_DR_A     = 16'h1000,
        S_DR_B     = 16'h2000,
        S_EM_RD    = 16'h4000,
        S_EM_OUT   = 16'h8000
    } t_state;

    t_state r_state, n_state;
    t_state w_sd_done;

    // Where a finished sift-down returns to.
    assign w_sd_done = i_status.drain ? S_DR_LOOP : S_ROOT_RD;

    always_comb begin
        n_state    = r_state;
        o_cmd      = ksmh_pkg::CMD_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd   = ksmh_pkg::CMD_LOAD;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_status.op)
                    ksmh_pkg::OP_INSERT: begin
                        if (i_status.not_full) begin
                            o_cmd   = ksmh_pkg::CMD_APPEND;
                            n_state = S_UP;
                        end else begin
                            o_cmd   = ksmh_pkg::CMD_RD_ROOT;
                            n_state = S_CHK_ROOT;
                        end
                    end
                    ksmh_pkg::OP_DRAIN: begin
                        if (i_status.count_zero) begin
                            o_cmd   = ksmh_pkg::CMD_EMPTY;
                            n_state = S_ROOT_OUT;
                        end else begin
                            o_cmd   = ksmh_pkg::CMD_DR_INIT;
                            n_state = S_DR_LOOP;
                        end
                    end
                    ksmh_pkg::OP_CLEAR: begin
                        o_cmd   = ksmh_pkg::CMD_CLEAR;
                        n_state = S_ROOT_OUT;
                    end
                    default: begin
                        o_cmd   = ksmh_pkg::CMD_DISCARD;
                        n_state = S_ROOT_RD;
                    end
                endcase
            end
            S_UP: begin
                if (i_status.node_zero) begin
                    o_cmd   = ksmh_pkg::CMD_WR_CUR;
                    n_state = S_ROOT_RD;
                end else begin
                    o_cmd   = ksmh_pkg::CMD_RD_PAR;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_status.gt_parent) begin
                    o_cmd   = ksmh_pkg::CMD_UP_MOVE;
                    n_state = S_UP;
                end else begin
                    o_cmd   = ksmh_pkg::CMD_WR_CUR;
                    n_state = S_ROOT_RD;
                end
            end
            S_CHK_ROOT: begin
                if (i_status.lt_root) begin
                    o_cmd   = ksmh_pkg::CMD_SD_INIT;
                    n_state = S_SD;
                end else begin
                    o_cmd   = ksmh_pkg::CMD_DISCARD;
                    n_state = S_ROOT_OUT;
                end
            end
            S_SD: begin
                if (i_status.has_l) begin
                    o_cmd   = ksmh_pkg::CMD_RD_L;
                    n_state = S_SD_L;
                end else begin
                    o_cmd   = ksmh_pkg::CMD_WR_CUR;
                    n_state = w_sd_done;
                end
            end
            S_SD_L: begin
                o_cmd   = ksmh_pkg::CMD_SD_L;
                n_state = i_status.has_r ? S_SD_R : S_SD_DEC;
            end
            S_SD_R: begin
                o_cmd   = ksmh_pkg::CMD_SD_R;
                n_state = S_SD_DEC;
            end
            S_SD_DEC: begin
                if (i_status.big_is_node) begin
                    o_cmd   = ksmh_pkg::CMD_WR_CUR;
                    n_state = w_sd_done;
                end else begin
                    o_cmd   = ksmh_pkg::CMD_SD_MOVE;
                    n_state = S_SD;
                end
            end
            S_ROOT_RD: begin
                o_cmd   = ksmh_pkg::CMD_RD_ROOT;
                n_state = S_ROOT_OUT;
            end
            S_ROOT_OUT: begin
                if (i_status.out_free) begin
                    o_cmd   = ksmh_pkg::CMD_EMIT_ROOT;
                    n_state = S_IDLE;
                end
            end
            S_DR_LOOP: begin
                if (i_status.i_zero) begin
                    o_cmd   = ksmh_pkg::CMD_EM_INIT;
                    n_state = S_EM_RD;
                end else begin
                    o_cmd   = ksmh_pkg::CMD_RD_ROOT;
                    n_state = S_DR_A;
                end
            end
            S_DR_A: begin
                o_cmd   = ksmh_pkg::CMD_DR_TMP;
                n_state = S_DR_B;
            end
            S_DR_B: begin
                o_cmd   = ksmh_pkg::CMD_DR_SWAP;
                n_state = S_SD;
            end
            S_EM_RD: begin
                o_cmd   = ksmh_pkg::CMD_EM_RD;
                n_state = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (i_status.out_free) begin
                    o_cmd   = ksmh_pkg::CMD_EM_OUT;
                    n_state = i_status.em_last ? S_IDLE : S_EM_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

[test/ksmh_checker.sv]
// Checker for the k-smallest heap: predicts results from accepted input beats and compares.
`timescale 1ns / 1ps
module ksmh_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ksmh_in_if          i_in,
    ksmh_out_if         i_out,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_beat_seen
);
    import ksmh_pkg::*;

    typedef struct packed {
        t_status    status;
        logic [31:0] key;
        logic [31:0] index;
        logic [5:0]  fill;
        logic        last;
    } t_result;

    logic [31:0] heap_key [32];
    logic [31:0] heap_id  [32];
    int          held;
    logic [5:0]  k_reg;
    t_result     awaited_results[$];

    function automatic int kept_limit();
        int k;
        k = k_reg;
        if (k == 0) k = 1;
        if (k > 32) k = 32;
        return k;
    endfunction

    task automatic swap_slots(input int a, input int b);
        logic [31:0] tk;
        logic [31:0] ti;
        tk = heap_key[a]; ti = heap_id[a];
        heap_key[a] = heap_key[b]; heap_id[a] = heap_id[b];
        heap_key[b] = tk; heap_id[b] = ti;
    endtask

    task automatic sift_down(input int node, input int bound);
        int big;
        int l;
        int r;
        while (node < bound) begin
            big = node; l = 2 * node + 1; r = 2 * node + 2;
            if (l < bound && heap_key[l] > heap_key[big]) big = l;
            if (r < bound && heap_key[r] > heap_key[big]) big = r;
            if (big == node) break;
            swap_slots(node, big);
            node = big;
        end
    endtask

    task automatic push_root(input t_status st);
        t_result res;
        res.status = st;
        res.key    = held > 0 ? heap_key[0] : '0;
        res.index  = held > 0 ? heap_id[0] : '0;
        res.fill   = 6'(held);
        res.last   = 1'b1;
        awaited_results.push_back(res);
    endtask

    task automatic predict_heap(input t_op op, input logic [31:0] key, input logic [31:0] id);
        int n;
        int p;
        t_result res;
        case (op)
            OP_INSERT: begin
                if (held < kept_limit()) begin
                    n = held;
                    heap_key[n] = key; heap_id[n] = id;
                    held++;
                    while (n > 0) begin
                        p = (n - 1) / 2;
                        if (!(heap_key[n] > heap_key[p])) break;
                        swap_slots(n, p);
                        n = p;
                    end
                    push_root(ST_APPEND);
                end else if (key < heap_key[0]) begin
                    heap_key[0] = key; heap_id[0] = id;
                    sift_down(0, held);
                    push_root(ST_REPLACE);
                end else begin
                    push_root(ST_DISCARD);
                end
            end
            OP_DRAIN: begin
                if (held == 0) begin
                    res = '{ST_EMPTY, '0, '0, '0, 1'b1};
                    awaited_results.push_back(res);
                end else begin
                    for (int i = held - 1; i > 0; i--) begin
                        swap_slots(0, i);
                        sift_down(0, i);
                    end
                    for (int i = 0; i < held; i++) begin
                        res = '{ST_DRAINED, heap_key[i], heap_id[i], 6'(held - 1 - i),
                                1'(i + 1 == held)};
                        awaited_results.push_back(res);
                    end
                    held = 0;
                end
            end
            OP_CLEAR: begin
                held = 0;
                res = '{ST_CLEARED, '0, '0, '0, 1'b1};
                awaited_results.push_back(res);
            end
            default: push_root(ST_DISCARD);
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            held  = 0;
            k_reg = K_RESET;
        end else begin
            // The output beat is compared before the input beat of the same edge is predicted,
            // since one item is in work at a time.
            if (i_out.valid && i_out.ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_out.status);
                        o_fail_count++;
                    end
                    if (i_out.out_key !== want.key) begin
                        $error("out_key: expected %h, actual %h", want.key, i_out.out_key);
                        o_fail_count++;
                    end
                    if (i_out.out_index !== want.index) begin
                        $error("out_index: expected %h, actual %h", want.index, i_out.out_index);
                        o_fail_count++;
                    end
                    if (i_out.fill_count !== want.fill) begin
                        $error("fill_count: expected %0d, actual %0d", want.fill, i_out.fill_count);
                        o_fail_count++;
                    end
                    if (i_out.last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, i_out.last);
                        o_fail_count++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                predict_heap(t_op'(i_in.operation), i_in.key_value, i_in.item_index);
            if (i_cfg_we) k_reg = i_cfg_wdata;
        end
        o_pending   <= awaited_results.size();
        o_beat_seen <= (i_in.valid && i_in.ready) || (i_out.valid && i_out.ready);
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_beat_seen  = 1'b0;
    end
endmodule

[test/testbench.sv]
// Top of the k-smallest heap testbench: stimulus, idling phases, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
    import ksmh_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [5:0] cfg_wdata;
    int         fail_count;
    int         pending;
    logic       beat_seen;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         quiet_cycles;

    ksmh_in_if  in_ch ();
    ksmh_out_if out_ch ();

    k_smallest_max_heap dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    ksmh_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_beat_seen  (beat_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // The watchdog ends the run once no beat has moved for far longer than the slowest item,
    // a full drain with every result stalled, would take.
    always @(posedge i_clk) begin
        if (beat_seen || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Offers one beat, with a random gap first, and holds it until it is accepted.
    // Valid is left high after the accepting edge; the next beat or wait_quiet replaces it
    // before the block can take another one.
    task automatic send_beat(input t_op op, input logic [31:0] key, input logic [31:0] id);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= op;
        in_ch.key_value  <= key;
        in_ch.item_index <= id;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Drops valid, waits until every expected result is out, then lets the block settle.
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // The register is written only once the block is idle.
    task automatic set_k(input logic [5:0] k);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // One key in four comes from a narrow range so that ties and replacements are common.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(15);
            default: return 32'($urandom_range(16'hffff)) << $urandom_range(16);
        endcase
    endfunction

    task automatic run_random(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 80) send_beat(OP_INSERT, pick_key(), $urandom());
            else if (r < 92) send_beat(OP_DRAIN, $urandom(), $urandom());
            else if (r < 97) send_beat(OP_CLEAR, $urandom(), $urandom());
            else send_beat(OP_RSVD, $urandom(), $urandom());
        end
    endtask

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.operation  = OP_INSERT;
        in_ch.key_value  = '0;
        in_ch.item_index = '0;
        out_ch.ready     = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        quiet_cycles     = 0;
        i_rst_n          = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty drain, reserved code on an empty heap, field extremes, equal keys,
        // a full heap at k = 1, k of zero acting as one, and k lowered below the fill.
        send_beat(OP_DRAIN, '0, '0);
        send_beat(OP_RSVD, '1, '1);
        send_beat(OP_INSERT, '1, '1);
        send_beat(OP_INSERT, '0, '0);
        send_beat(OP_INSERT, 32'h0001_8000, 32'h5555_aaaa);
        send_beat(OP_INSERT, 32'h0001_8000, 32'haaaa_5555);
        send_beat(OP_RSVD, '0, '0);
        send_beat(OP_DRAIN, '0, '0);
        set_k(6'd1);
        send_beat(OP_INSERT, 32'd50, 32'd1);
        send_beat(OP_INSERT, 32'd60, 32'd2);
        send_beat(OP_INSERT, 32'd40, 32'd3);
        send_beat(OP_INSERT, 32'd40, 32'd4);
        send_beat(OP_CLEAR, '0, '0);
        set_k(6'd0);
        send_beat(OP_INSERT, 32'd7, 32'd7);
        send_beat(OP_INSERT, 32'd3, 32'd8);
        set_k(6'd4);
        for (int i = 0; i < 3; i++) send_beat(OP_INSERT, 32'd10 + i, i);
        set_k(6'd2);
        send_beat(OP_INSERT, 32'd11, 32'd20);
        send_beat(OP_INSERT, 32'd1, 32'd21);
        send_beat(OP_DRAIN, '0, '0);

        // Random phases with the different idling patterns and several k settings.
        set_k(6'd63);
        run_random(30);
        // Pause until every result has come before going on.
        wait_quiet();
        send_idle_pct = 67;
        set_k(6'd32);
        run_random(20);
        send_idle_pct = 0;
        recv_stall_pct = 67;
        set_k(6'd5);
        run_random(20);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        set_k(6'd32);
        run_random(25);
        send_beat(OP_DRAIN, '0, '0);

        wait_quiet();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ksmh_pkg.sv
hw/rtl/ksmh_in_if.sv
hw/rtl/ksmh_out_if.sv
hw/rtl/ksmh_ram.sv
hw/rtl/ksmh_datapath.sv
hw/rtl/ksmh_ctrl.sv
hw/rtl/k_smallest_max_heap.sv
test/ksmh_checker.sv
test/testbench.sv
